[src/cicmd_pkg.sv]
package cicmd_pkg;

  localparam int GRID_SIZE = 32;
  localparam int AXIS_W    = $clog2(GRID_SIZE);
  localparam int ADDR_W    = 3 * AXIS_W;
  localparam int VAL_W     = 48;
  localparam int FRAC_W    = 16;
  localparam int WGT_W     = FRAC_W + 1;
  localparam int Q_DEPTH   = 2;

  localparam logic [WGT_W-1:0] ONE_Q16   = WGT_W'(1) << FRAC_W;
  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

  localparam logic [1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  typedef enum logic [1:0] {OP_DEP, OP_READ, OP_CLR} op_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_t;

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_WA, B_WB, B_WC, B_WR, B_RQ, B_CLR
  } back_state_t;

  typedef struct packed {
    op_t                          op;
    logic [2:0][AXIS_W-1:0]       coord;
    logic [2:0][FRAC_W-1:0]       frac;
    logic [31:0]                  mass;
    logic [ADDR_W-1:0]            index;
  } item_t;

endpackage

[src/cicmd_front.sv]
module cicmd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          inv_spacing,
  input  logic                 init_busy,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_y,
  input  logic signed [31:0]   pos_z,
  input  logic [31:0]          mass,
  input  logic [14:0]          cell_index,
  output logic                 q_push,
  output cicmd_pkg::item_t     q_item,
  input  logic                 q_full
);

  cicmd_pkg::front_state_t state, state_next;
  cicmd_pkg::item_t        item;
  logic signed [2:0][31:0] pos;
  logic [1:0]              axis;
  logic signed [31:0]      pos_sel;
  logic signed [64:0]      prod;
  logic                    accept;

  assign in_ready = (state == cicmd_pkg::F_IDLE) && !init_busy;
  assign accept   = in_valid && in_ready;
  assign q_push   = (state == cicmd_pkg::F_PUSH) && !q_full;
  assign q_item   = item;

  always_comb begin
    case (axis)
      2'd0:    pos_sel = pos[0];
      2'd1:    pos_sel = pos[1];
      default: pos_sel = pos[2];
    endcase
  end

  // signed position times unsigned spacing: coordinate in signed Q33.32
  assign prod = pos_sel * $signed({1'b0, inv_spacing});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cicmd_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cicmd_pkg::F_IDLE: begin
        if (accept) begin
          unique case (cmd)
            cicmd_pkg::CMD_DEPOSIT: state_next = cicmd_pkg::F_MUL;
            cicmd_pkg::CMD_READ,
            cicmd_pkg::CMD_CLEAR:   state_next = cicmd_pkg::F_PUSH;
            default:                state_next = cicmd_pkg::F_IDLE;
          endcase
        end
      end
      cicmd_pkg::F_MUL: begin
        if (axis == 2'd2) state_next = cicmd_pkg::F_PUSH;
      end
      cicmd_pkg::F_PUSH: begin
        if (!q_full) state_next = cicmd_pkg::F_IDLE;
      end
      default: state_next = cicmd_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos[0]     <= pos_x;
      pos[1]     <= pos_y;
      pos[2]     <= pos_z;
      item.mass  <= mass;
      item.index <= cell_index[cicmd_pkg::ADDR_W-1:0];
      axis       <= 2'd0;
      case (cmd)
        cicmd_pkg::CMD_READ:  item.op <= cicmd_pkg::OP_READ;
        cicmd_pkg::CMD_CLEAR: item.op <= cicmd_pkg::OP_CLR;
        default:              item.op <= cicmd_pkg::OP_DEP;
      endcase
    end else if (state == cicmd_pkg::F_MUL) begin
      // floor then wrap: low bits of the two's complement integer part
      item.coord[axis] <= prod[32 +: cicmd_pkg::AXIS_W];
      item.frac[axis]  <= prod[16 +: cicmd_pkg::FRAC_W];
      axis             <= axis + 2'd1;
    end
  end

endmodule

[src/cicmd_queue.sv]
module cicmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cicmd_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output cicmd_pkg::item_t head_item
);

  localparam int PTR_W = $clog2(cicmd_pkg::Q_DEPTH);

  cicmd_pkg::item_t            slots [cicmd_pkg::Q_DEPTH];
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [PTR_W:0]              count;

  assign full       = count == (PTR_W + 1)'(cicmd_pkg::Q_DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(cicmd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(cicmd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

[src/cicmd_back.sv]
module cicmd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  cicmd_pkg::item_t             head_item,
  output logic                         pop,
  output logic                         init_busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cicmd_pkg::VAL_W-1:0]  cell_value,
  output logic                         saturated
);

  localparam int AW = cicmd_pkg::ADDR_W;
  localparam int VW = cicmd_pkg::VAL_W;
  localparam int WW = cicmd_pkg::WGT_W;
  localparam int FW = cicmd_pkg::FRAC_W;
  localparam int NA = cicmd_pkg::AXIS_W;

  logic [VW-1:0]   mem [2**AW];
  logic [VW-1:0]   rd_data;
  logic [AW-1:0]   mem_ra;
  logic [AW-1:0]   mem_wa;
  logic [VW-1:0]   mem_wd;
  logic            mem_we;

  cicmd_pkg::back_state_t state, state_next;
  logic [2:0]      corner;
  logic [AW-1:0]   clr_cnt;
  logic [WW-1:0]   wxy;
  logic [WW-1:0]   wt;
  logic [31:0]     add;
  logic            sat_flag;

  logic [2:0][WW-1:0]  w;
  logic [2:0][NA-1:0]  g;
  logic [AW-1:0]       dep_addr;
  logic [2*WW-1:0]     p_xy;
  logic [2*WW-1:0]     p_t;
  logic [32+WW-1:0]    p_m;
  logic [VW:0]         sum;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // corner bit 2 is x, bit 0 is z
      w[a] = corner[2-a] ? {1'b0, head_item.frac[a]}
                         : cicmd_pkg::ONE_Q16 - {1'b0, head_item.frac[a]};
      g[a] = head_item.coord[a] + NA'(corner[2-a]);
    end
  end

  assign dep_addr = {g[0], g[1], g[2]};
  assign p_xy     = w[0] * w[1];
  assign p_t      = wxy * w[2];
  assign p_m      = head_item.mass * wt;
  assign sum      = {1'b0, rd_data} + (VW + 1)'(add);

  assign init_busy = state == cicmd_pkg::B_INIT;
  assign mem_ra    = (head_item.op == cicmd_pkg::OP_READ) ? head_item.index : dep_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cicmd_pkg::B_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = dep_addr;
    mem_wd     = sum[VW] ? cicmd_pkg::VALUE_MAX : sum[VW-1:0];
    unique case (state)
      cicmd_pkg::B_INIT,
      cicmd_pkg::B_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = '0;
        if (clr_cnt == {AW{1'b1}}) begin
          state_next = cicmd_pkg::B_IDLE;
          pop        = state == cicmd_pkg::B_CLR;
        end
      end
      cicmd_pkg::B_IDLE: begin
        if (head_valid) begin
          unique case (head_item.op)
            cicmd_pkg::OP_DEP:  state_next = cicmd_pkg::B_WA;
            cicmd_pkg::OP_CLR:  state_next = cicmd_pkg::B_CLR;
            default: begin
              // rd_data is valid next cycle for the held index
              if (!out_valid || out_ready) state_next = cicmd_pkg::B_RQ;
            end
          endcase
        end
      end
      cicmd_pkg::B_RQ: begin
        pop        = 1'b1;
        state_next = cicmd_pkg::B_IDLE;
      end
      cicmd_pkg::B_WA: state_next = cicmd_pkg::B_WB;
      cicmd_pkg::B_WB: state_next = cicmd_pkg::B_WC;
      cicmd_pkg::B_WC: state_next = cicmd_pkg::B_WR;
      cicmd_pkg::B_WR: begin
        mem_we = 1'b1;
        if (corner == 3'd7) begin
          pop        = 1'b1;
          state_next = cicmd_pkg::B_IDLE;
        end else begin
          state_next = cicmd_pkg::B_WA;
        end
      end
      default: state_next = cicmd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      corner    <= '0;
      sat_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == cicmd_pkg::B_INIT || state == cicmd_pkg::B_CLR) begin
        clr_cnt  <= clr_cnt + 1'b1;
        sat_flag <= 1'b0;
      end
      if (state == cicmd_pkg::B_WR) begin
        corner <= corner + 3'd1;
        if (sum[VW]) sat_flag <= 1'b1;
      end
      if (state == cicmd_pkg::B_RQ) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wxy <= p_xy[FW +: WW];
    wt  <= p_t[FW +: WW];
    add <= p_m[FW +: 32];
    if (state == cicmd_pkg::B_RQ) begin
      cell_value <= rd_data;
      saturated  <= sat_flag;
    end
  end

endmodule

[src/cic_mass_deposit_3d.sv]
// Cloud-in-cell mass deposit onto a periodic 32x32x32 grid of 48-bit Q32.16
// cells, held in one simple dual-port block memory. A front stage takes a
// request, forms the three grid coordinates with one 32x33 multiplier (one axis
// at a time for a deposit) and hands it through a two-entry queue to the back
// stage, which owns the memory. For each neighbor cell the back stage steps
// through B_WA, B_WB, B_WC and B_WR (x-y weight product, times z weight, times
// mass along with the read, saturating write). The front can take the next
// request while the back stage is busy, as long as the queue has room. A read
// returns one result; a clear sweeps all 32768 cells at one cell per cycle.
// After reset the same sweep runs and in_ready stays low until it ends; the
// spacing register can be written at any time the block is idle.
module cic_mass_deposit_3d (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [31:0]                  cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   cmd,
  input  logic signed [31:0]           pos_x,
  input  logic signed [31:0]           pos_y,
  input  logic signed [31:0]           pos_z,
  input  logic [31:0]                  mass,
  input  logic [14:0]                  cell_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [47:0]                  cell_value,
  output logic                         saturated
);

  logic [31:0]      inv_spacing;
  logic             init_busy;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             head_valid;
  cicmd_pkg::item_t push_item;
  cicmd_pkg::item_t head_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing <= 32'h0001_0000;
    end else if (cfg_wr_en) begin
      inv_spacing <= cfg_wr_data;
    end
  end

  cicmd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .inv_spacing (inv_spacing),
    .init_busy   (init_busy),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .mass        (mass),
    .cell_index  (cell_index),
    .q_push      (q_push),
    .q_item      (push_item),
    .q_full      (q_full)
  );

  cicmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  cicmd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (q_pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_value (cell_value),
    .saturated  (saturated)
  );

endmodule
